// ===== rtl/smgr_pkg.sv =====
// ----------------------------------------------------------------------------
// smgr_pkg: shared types and constants
// Widths, defaults and the controller/datapath interface of the bounded value
// set with closest-pair and range statistics.
// ----------------------------------------------------------------------------
package smgr_pkg;

	localparam int VALUE_W        = 32;
	localparam int LIMIT_W        = 11;
	localparam int CAPACITY_DEF   = 1024;
	localparam int MIN_SPAN_COUNT = 2;
	localparam int OUT_DATA_W     = 80;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_value;   // capture the incoming value
		logic decide;       // judge full or not, restart the scan index
		logic rd_issue;     // read one stored entry and step the index
		logic commit;       // store the value and update count, min and max
		logic load_result;  // move the result into the output register
	} smgr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic last_idx;
		logic pipe_busy;
		logic out_free;
	} smgr_stat_t;

endpackage

// ===== rtl/smgr_ram.sv =====
// ----------------------------------------------------------------------------
// smgr_ram: generic single-port RAM
// One address port shared by read and write, read data registered.
// ----------------------------------------------------------------------------
module smgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/smgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smgr_ctrl: sequencing controller
// Accepts one value; unless the set is full, scans the stored values (if any)
// and commits the value; then hands the result to the output register.
// ----------------------------------------------------------------------------
module smgr_ctrl
	import smgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  smgr_stat_t stat,
	output smgr_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_value = 1'b1;
					state_d        = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.decide = 1'b1;
				if (stat.full) begin
					state_d = ST_RESULT;
				end else if (stat.empty) begin
					state_d = ST_COMMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (stat.last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// Wait until the last gap has passed the compare stage.
				if (!stat.pipe_busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/smgr_dpath.sv =====
// ----------------------------------------------------------------------------
// smgr_dpath: datapath
// Value store, scan index, gap pipeline, running statistics and the output
// register.
// ----------------------------------------------------------------------------
module smgr_dpath
	import smgr_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [LIMIT_W-1:0]    cfg_wdata,
	input  logic [VALUE_W-1:0]    in_value,
	input  smgr_cmd_t             cmd,
	output smgr_stat_t            stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int PAD_W  = OUT_DATA_W - (1 + LIMIT_W + 1 + 2 * VALUE_W);

	logic [LIMIT_W-1:0]        limit_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [VALUE_W-1:0] min_q;
	logic signed [VALUE_W-1:0] max_q;
	logic [VALUE_W-1:0]        best_q;
	logic [ADDR_W-1:0]         idx_q;
	logic                      status_q;
	logic                      rd_v_s1;
	logic                      gap_v_s2;
	logic [VALUE_W-1:0]        gap_s2;
	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;

	logic [CMP_W-1:0]          eff_limit;
	logic                      full;
	logic [ADDR_W-1:0]         ram_addr;
	logic [VALUE_W-1:0]        ram_rdata;
	logic signed [VALUE_W:0]   diff_ab;
	logic signed [VALUE_W:0]   diff_ba;
	logic signed [VALUE_W:0]   span_wide;
	logic                      spans_valid;

	// A limit above the store size is clipped to the store size.
	assign eff_limit = (CMP_W'(limit_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
	                                                        : CMP_W'(limit_q);
	assign full      = (CMP_W'(count_q) >= eff_limit);

	assign ram_addr  = cmd.commit ? count_q[ADDR_W-1:0] : idx_q;

	smgr_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.commit),
		.addr  (ram_addr),
		.wdata (value_q),
		.rdata (ram_rdata)
	);

	// Both differences are formed so that the absolute one is a plain select.
	assign diff_ab = {value_q[VALUE_W-1], value_q} - {ram_rdata[VALUE_W-1], ram_rdata};
	assign diff_ba = {ram_rdata[VALUE_W-1], ram_rdata} - {value_q[VALUE_W-1], value_q};

	assign span_wide   = {max_q[VALUE_W-1], max_q} - {min_q[VALUE_W-1], min_q};
	assign spans_valid = (count_q >= CNT_W'(MIN_SPAN_COUNT));

	always_comb begin
		stat.full      = full;
		stat.empty     = (count_q == '0);
		stat.last_idx  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
		stat.pipe_busy = rd_v_s1 | gap_v_s2;
		stat.out_free  = !out_valid_q | out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= '0;
			count_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			best_q      <= '1;
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			gap_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.decide) begin
				idx_q <= '0;
			end else if (cmd.rd_issue) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			rd_v_s1  <= cmd.rd_issue;
			gap_v_s2 <= rd_v_s1;
			if (gap_v_s2 && (gap_s2 < best_q)) begin
				best_q <= gap_s2;
			end
			if (cmd.commit) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					min_q <= value_q;
					max_q <= value_q;
				end else begin
					if (value_q < min_q) begin
						min_q <= value_q;
					end
					if (value_q > max_q) begin
						max_q <= value_q;
					end
				end
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			value_q <= in_value;
		end
		if (cmd.decide) begin
			status_q <= full;
		end
		if (rd_v_s1) begin
			gap_s2 <= diff_ab[VALUE_W] ? diff_ba[VALUE_W-1:0] : diff_ab[VALUE_W-1:0];
		end
		if (cmd.load_result) begin
			out_data_q <= {
				{PAD_W{1'b0}},
				(spans_valid ? span_wide[VALUE_W-1:0] : {VALUE_W{1'b0}}),
				(spans_valid ? best_q : {VALUE_W{1'b0}}),
				spans_valid,
				LIMIT_W'(count_q),
				status_q
			};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/set_min_gap_and_range.sv =====
// Sequence: a value is compared with the n values already held, one per cycle
// through the single store port, then committed; the first value skips the scan
// and a rejected one goes straight to the result. A new value is accepted only
// once the result of the last one has been loaded into the output register.
// Reset (arst_n low): the set is empty, the limit is zero, the smallest gap is
// all ones; stored entries are not cleared and are never read before written.
// ----------------------------------------------------------------------------
// set_min_gap_and_range: bounded value set with gap and range statistics
// Holds signed values up to a configured limit and reports the smallest gap
// between any two held values and the span from the smallest to the largest.
// ----------------------------------------------------------------------------
module set_min_gap_and_range
	import smgr_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [LIMIT_W-1:0]    cfg_wdata,      // capacity_limit
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [VALUE_W-1:0]    s_axis_tdata,   // value
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status, held_count, spans_valid, shortest_gap, longest_span, zero padding
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	smgr_cmd_t  cmd;
	smgr_stat_t stat;

	smgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smgr_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== test/set_min_gap_and_range_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_min_gap_and_range_tb: self-checking testbench for the bounded value set
// A short table of directed values is followed by random phases under changing
// capacity limits, and then by a short run without idling. Every
// transaction on the input stream is predicted, and every result is checked
// field by field. Both streams idle in random bursts, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module set_min_gap_and_range_tb;
	import smgr_pkg::*;

	localparam int CAPACITY      = CAPACITY_DEF;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int RANDOM_ITEMS  = 490;
	localparam int DIRECTED_ROWS = 13;

	typedef struct packed {
		logic               status;
		logic [LIMIT_W-1:0] held;
		logic               valid;
		logic [VALUE_W-1:0] gap;
		logic [VALUE_W-1:0] span;
	} set_report_t;

	typedef struct packed {
		logic               write_limit;
		logic [LIMIT_W-1:0] limit;
		logic [VALUE_W-1:0] value;
		logic               typed;
		set_report_t        want;
	} directed_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]    cfg_wdata = '0;
	logic                  s_valid   = 1'b0;
	logic [VALUE_W-1:0]    s_data    = '0;
	logic                  m_ready   = 1'b0;
	logic                  s_axis_tready;
	logic                  m_axis_tvalid;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	set_min_gap_and_range #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Own copy of the set and its statistics.
	logic signed [VALUE_W-1:0] stored [CAPACITY];
	int                        held_values = 0;
	logic signed [VALUE_W-1:0] set_min     = '0;
	logic signed [VALUE_W-1:0] set_max     = '0;
	logic [VALUE_W-1:0]        min_gap     = '1;
	logic [LIMIT_W-1:0]        cap_limit   = '0;

	set_report_t   expected_results [$];
	directed_row_t directed_rows [DIRECTED_ROWS];
	int            errors          = 0;
	int            results_seen    = 0;
	int            rejected_values = 0;
	int            limit_writes    = 0;
	int            stall_left      = 0;
	int            hold_left       = 0;
	bit            quiet           = 1'b0;
	bit            pressure_done   = 1'b0;

	function automatic set_report_t add_to_set(logic signed [VALUE_W-1:0] v);
		set_report_t             r;
		int                      limit;
		int                      i;
		logic signed [VALUE_W:0] d;
		limit = (int'(cap_limit) > CAPACITY) ? CAPACITY : int'(cap_limit);
		if (held_values >= limit) begin
			r.status = 1'b1;
			rejected_values++;
		end else begin
			r.status = 1'b0;
			for (i = 0; i < held_values; i++) begin
				// Differences are taken at one bit more than the values.
				d = {v[VALUE_W-1], v} - {stored[i][VALUE_W-1], stored[i]};
				if (d < 0)
					d = -d;
				if (d[VALUE_W-1:0] < min_gap)
					min_gap = d[VALUE_W-1:0];
			end
			if (held_values == 0) begin
				set_min = v;
				set_max = v;
			end else begin
				if (v < set_min)
					set_min = v;
				if (v > set_max)
					set_max = v;
			end
			stored[held_values] = v;
			held_values++;
		end
		d       = {set_max[VALUE_W-1], set_max} - {set_min[VALUE_W-1], set_min};
		r.held  = LIMIT_W'(held_values);
		r.valid = held_values >= MIN_SPAN_COUNT;
		r.gap   = r.valid ? min_gap : '0;
		r.span  = r.valid ? d[VALUE_W-1:0] : '0;
		return r;
	endfunction

	// Values come from a window of the given width around zero; near copies of
	// held values are mixed in only when asked, as they drive the gap to zero.
	function automatic logic [VALUE_W-1:0] pick_value(int width, bit near_ok);
		logic [VALUE_W-1:0] r;
		int                 pick;
		pick = $urandom_range(0, 19);
		if (near_ok && held_values > 0 && pick < 4)
			r = stored[$urandom_range(0, held_values - 1)] + VALUE_W'($urandom_range(0, 6)) - 3;
		else if (width >= VALUE_W && pick == 4)
			r = 32'h8000_0000;
		else if (width >= VALUE_W && pick == 5)
			r = 32'h7FFF_FFFF;
		else if (width >= VALUE_W)
			r = $urandom;
		else
			r = ($urandom & ((32'd1 << width) - 1)) - (32'd1 << (width - 1));
		return r;
	endfunction

	function automatic int field_errors(string name, logic [VALUE_W-1:0] want,
			logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_value(logic [VALUE_W-1:0] v, bit typed, set_report_t want);
		set_report_t predicted;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = add_to_set(v);
		expected_results.insert(expected_results.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] lim);
		s_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cap_limit = lim;
		limit_writes++;
		@(negedge clk);
	endtask

	// Receiver: random stalls, one long hold-off, and the in-order check.
	initial begin
		set_report_t want;
		set_report_t got;
		forever begin
			@(negedge clk);
			if (!pressure_done && results_seen >= 40 && s_valid) begin
				pressure_done = 1'b1;
				hold_left     = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				m_ready <= 1'b0;
			end else begin
				m_ready <= 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_ready) begin
				results_seen++;
				got.status = m_axis_tdata[0];
				got.held   = m_axis_tdata[11:1];
				got.valid  = m_axis_tdata[12];
				got.gap    = m_axis_tdata[44:13];
				got.span   = m_axis_tdata[76:45];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, actual %h",
						$time, m_axis_tdata);
				end else begin
					want = expected_results.pop_front();
					errors += field_errors("status", 32'(want.status), 32'(got.status));
					errors += field_errors("held_count", 32'(want.held), 32'(got.held));
					errors += field_errors("spans_valid", 32'(want.valid), 32'(got.valid));
					errors += field_errors("shortest_gap", want.gap, got.gap);
					errors += field_errors("longest_span", want.span, got.span);
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t ns: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
		$display("set_min_gap_and_range_tb failed");
		$finish;
	end

	initial begin
		int                 row;
		int                 phase;
		int                 n;
		int                 width;
		int                 random_sent;
		logic [LIMIT_W-1:0] lim;

		// The limit is zero after reset, so the first rows are all rejected.
		directed_rows[0]  = '{1'b0, 11'd0, 32'h7FFF_FFFF, 1'b1, '{1'b1, 11'd0, 1'b0, 32'h0, 32'h0}};
		directed_rows[1]  = '{1'b0, 11'd0, 32'h8000_0000, 1'b1, '{1'b1, 11'd0, 1'b0, 32'h0, 32'h0}};
		directed_rows[2]  = '{1'b0, 11'd0, 32'h0000_0000, 1'b1, '{1'b1, 11'd0, 1'b0, 32'h0, 32'h0}};
		directed_rows[3]  = '{1'b0, 11'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 11'd0, 1'b0, 32'h0, 32'h0}};
		directed_rows[4]  = '{1'b1, 11'd1, 32'h0000_1000, 1'b1, '{1'b0, 11'd1, 1'b0, 32'h0, 32'h0}};
		directed_rows[5]  = '{1'b0, 11'd0, 32'h7FFF_FFFF, 1'b1, '{1'b1, 11'd1, 1'b0, 32'h0, 32'h0}};
		directed_rows[6]  = '{1'b1, 11'd3, 32'h0000_3000, 1'b1,
			'{1'b0, 11'd2, 1'b1, 32'h2000, 32'h2000}};
		directed_rows[7]  = '{1'b0, 11'd0, 32'hFFFF_F000, 1'b1,
			'{1'b0, 11'd3, 1'b1, 32'h2000, 32'h4000}};
		directed_rows[8]  = '{1'b0, 11'd0, 32'h8000_0000, 1'b1,
			'{1'b1, 11'd3, 1'b1, 32'h2000, 32'h4000}};
		// Limit lowered below the count: held values stay, new ones are refused.
		directed_rows[9]  = '{1'b1, 11'd1, 32'h0000_0005, 1'b1,
			'{1'b1, 11'd3, 1'b1, 32'h2000, 32'h4000}};
		directed_rows[10] = '{1'b1, 11'd2047, 32'h0000_2800, 1'b0, '0};
		directed_rows[11] = '{1'b0, 11'd0, 32'h0000_4000, 1'b0, '0};
		directed_rows[12] = '{1'b0, 11'd0, 32'hFFFF_E000, 1'b0, '0};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_rows[row].write_limit)
				set_limit(directed_rows[row].limit);
			send_value(directed_rows[row].value, directed_rows[row].typed,
				directed_rows[row].want);
		end

		// Random phases: the value window widens phase by phase so that the
		// minimum, maximum and gap keep moving for a good while.
		phase       = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       lim = LIMIT_W'($urandom_range(0, held_values));
				1, 2:    lim = LIMIT_W'(held_values + $urandom_range(1, 20));
				default: lim = LIMIT_W'($urandom_range(0, 2047));
			endcase
			set_limit(lim);
			n     = $urandom_range(12, 36);
			width = (20 + phase > VALUE_W) ? VALUE_W : 20 + phase;
			repeat (n)
				send_value(pick_value(width, phase >= 10), 1'b0, '0);
			random_sent += n;
			phase++;
		end

		// Last part without idling: values close to held ones up to a limit
		// and past it, then a limit far above the count.
		quiet = 1'b1;
		set_limit(LIMIT_W'(held_values + 40));
		repeat (60)
			send_value(pick_value(VALUE_W, 1'b1), 1'b0, '0);
		set_limit('1);
		repeat (4)
			send_value(pick_value(VALUE_W, 1'b0), 1'b0, '0);

		s_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d results over %0d limit settings; %0d values refused.",
			results_seen, limit_writes, rejected_values);
		$display("The set ended with %0d entries held, with %0d mismatches.",
			held_values, errors);
		if (errors == 0)
			$display("set_min_gap_and_range_tb passed");
		else
			$display("set_min_gap_and_range_tb failed");
		$finish;
	end

endmodule
